// File: hw/rtl/mmnhc_pkg.sv
// ----------------------------------------------------------------------------
// mmnhc_pkg
// shared types and constants of the min/max normalize hue colormap
// ----------------------------------------------------------------------------
package mmnhc_pkg;

    localparam int SAMPLE_BITS        = 24;
    localparam int FRACTION_BITS_DEF  = 16;
    localparam int HUE_BITS           = 9;
    localparam int BYTE_BITS          = 8;
    localparam int SEXT_BITS          = 3;

    localparam logic [HUE_BITS-1:0] HUE_SPAN_RESET = HUE_BITS'(250);
    localparam int                  SEXTANT_DEG    = 60;
    localparam int                  SEXTANT_COUNT  = 6;

    // extremes of the signed sample range, used as running min/max sentinels
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_HI =
        {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_LO =
        {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // hsv sextants
    localparam logic [SEXT_BITS-1:0] SEXT_RED_YELLOW    = SEXT_BITS'(0);
    localparam logic [SEXT_BITS-1:0] SEXT_YELLOW_GREEN  = SEXT_BITS'(1);
    localparam logic [SEXT_BITS-1:0] SEXT_GREEN_CYAN    = SEXT_BITS'(2);
    localparam logic [SEXT_BITS-1:0] SEXT_CYAN_BLUE     = SEXT_BITS'(3);
    localparam logic [SEXT_BITS-1:0] SEXT_BLUE_MAGENTA  = SEXT_BITS'(4);

    localparam logic FUNC_MEASURE  = 1'b0;
    localparam logic FUNC_COLORIZE = 1'b1;

    typedef struct packed {
        logic                          func;
        logic signed [SAMPLE_BITS-1:0] sample_value;
        logic                          pass_end;
    } sample_word_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0]          red;
        logic [BYTE_BITS-1:0]          green;
        logic [BYTE_BITS-1:0]          blue;
        logic signed [SAMPLE_BITS-1:0] min_seen;
        logic signed [SAMPLE_BITS-1:0] max_seen;
    } pixel_word_t;

endpackage

// File: hw/rtl/minmax_normalize_hue_colormap.sv
// ----------------------------------------------------------------------------
// minmax_normalize_hue_colormap
// two-pass min/max normalizer with an hsv hue colormap, bit-serial datapath
// ----------------------------------------------------------------------------
// A measure word (func 0) updates the running maximum and the running minimum
// of nonzero samples and gives no output word; pass_end makes the next measure
// word restart both extremes from the range sentinels. A colorize word (func 1)
// is normalized to v = (x - min) / (max - min) in Q1.F, mapped to hue
// (1 - v) * hue_span degrees and turned into an 8-bit rgb triple by the hsv
// sextant rule, together with the current min and max. On its way from
// acceptance to the output register, one shared restoring divider retires one
// quotient bit per cycle, first FRACTION_BITS bits of the normalize quotient,
// then FRACTION_BITS + 9 bits of the hue divided by 60, with the hue product
// taken between the two divisions and the output register loaded last. A flat
// range or a sample clamped to 0 or 1 skips the normalize division. The block
// goes back to idle as the output register loads and only then takes the next
// word, so it takes no new word while a colorize word is in work; measure words
// go one per cycle while the block is idle. The input stalls while a colorize
// word is in work; a finished word sits in the output register and does not
// hold back the next input word, but a second colorize word waits in its last
// step until the receiver has taken the first. The user must write hue_span
// through cfg_wr_en / cfg_wr_data only while the block is idle; the block
// itself does not enforce it.
// ----------------------------------------------------------------------------
module minmax_normalize_hue_colormap #(
    parameter int FRACTION_BITS = mmnhc_pkg::FRACTION_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [mmnhc_pkg::HUE_BITS-1:0]   cfg_wr_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  mmnhc_pkg::sample_word_t          in_word,
    output logic                             out_valid,
    input  logic                             out_stall,
    output mmnhc_pkg::pixel_word_t           out_word
);
    import mmnhc_pkg::*;

    // hue product width, normalized value width, divider counter width, byte product width
    localparam int HQ_W  = FRACTION_BITS + HUE_BITS;
    localparam int V_W   = FRACTION_BITS + 1;
    localparam int CNT_W = $clog2(HQ_W + 1);
    localparam int BY_W  = FRACTION_BITS + BYTE_BITS + 1;

    localparam logic [V_W-1:0]         V_ONE    = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] DIV_SEXT = SAMPLE_BITS'(SEXTANT_DEG);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_V,
        ST_MULT,
        ST_DIV_H,
        ST_FINISH
    } state_t;

    state_t                         state_reg, state_next;
    logic                           restart_reg, restart_next;
    logic signed [SAMPLE_BITS-1:0]  min_reg, min_next;
    logic signed [SAMPLE_BITS-1:0]  max_reg, max_next;
    logic [HUE_BITS-1:0]            hue_reg, hue_next;
    logic [V_W-1:0]                 v_reg, v_next;
    logic [SAMPLE_BITS-1:0]         rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0]         dsr_reg, dsr_next;
    logic [HQ_W-1:0]                dvd_reg, dvd_next;
    logic [HQ_W-1:0]                quo_reg, quo_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic                           out_valid_reg, out_valid_next;
    pixel_word_t                    out_word_reg, out_word_next;

    // accept, measure-pass and colorize setup signals
    logic                           accept;
    logic signed [SAMPLE_BITS-1:0]  start_min, start_max;
    logic                           flat, below;
    logic [SAMPLE_BITS:0]           num_wide, den_wide;
    logic [SAMPLE_BITS-1:0]         num, den;

    // divider step
    logic [SAMPLE_BITS:0]           trial;
    logic                           q_bit;
    logic [SAMPLE_BITS-1:0]         rem_step;

    // hue product and color stage
    logic [V_W+HUE_BITS-1:0]        hq_wide;
    logic [HUE_BITS-1:0]            sext_raw;
    logic [SEXT_BITS-1:0]           sext;
    logic [FRACTION_BITS-1:0]       frac;
    logic [V_W-1:0]                 q_arg;
    logic [BY_W-1:0]                t_wide, q_wide;
    logic [BYTE_BITS-1:0]           t_byte, q_byte, one_byte, zero_byte;
    logic [BYTE_BITS-1:0]           red, green, blue;
    logic                           out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // measure pass: min restarts at the top, max at the bottom after pass_end
    assign start_min = restart_reg ? SAMPLE_HI : min_reg;
    assign start_max = restart_reg ? SAMPLE_LO : max_reg;

    // colorize setup: empty range or sample at/below min gives v = 0
    assign flat     = (max_reg <= min_reg) || (in_word.sample_value <= min_reg);
    assign num_wide = {in_word.sample_value[SAMPLE_BITS-1], in_word.sample_value}
                    - {min_reg[SAMPLE_BITS-1], min_reg};
    assign den_wide = {max_reg[SAMPLE_BITS-1], max_reg}
                    - {min_reg[SAMPLE_BITS-1], min_reg};
    assign num      = num_wide[SAMPLE_BITS-1:0];
    assign den      = den_wide[SAMPLE_BITS-1:0];
    assign below    = (num < den);

    // one restoring division step, shared by both divisions
    assign trial    = {rem_reg, dvd_reg[HQ_W-1]};
    assign q_bit    = (trial >= {1'b0, dsr_reg});
    assign rem_step = q_bit ? SAMPLE_BITS'(trial - {1'b0, dsr_reg})
                            : trial[SAMPLE_BITS-1:0];

    // hue in Q.F degrees
    assign hq_wide  = (V_ONE - v_reg) * hue_reg;

    // quotient of hue / 60: integer part is the sextant, fraction is f
    assign sext_raw = quo_reg[HQ_W-1:FRACTION_BITS];
    assign sext     = (sext_raw >= HUE_BITS'(SEXTANT_COUNT))
                    ? SEXT_BITS'(sext_raw - HUE_BITS'(SEXTANT_COUNT))
                    : SEXT_BITS'(sext_raw);
    assign frac     = quo_reg[FRACTION_BITS-1:0];
    assign q_arg    = V_ONE - {1'b0, frac};

    // component byte = floor(c * 255 / 2^F)
    assign t_wide    = {1'b0, frac, {BYTE_BITS{1'b0}}} - BY_W'(frac);
    assign q_wide    = {q_arg, {BYTE_BITS{1'b0}}} - BY_W'(q_arg);
    assign t_byte    = t_wide[FRACTION_BITS+BYTE_BITS-1:FRACTION_BITS];
    assign q_byte    = q_wide[FRACTION_BITS+BYTE_BITS-1:FRACTION_BITS];
    assign one_byte  = {BYTE_BITS{1'b1}};
    assign zero_byte = '0;

    always_comb
    begin
        case (sext)
            SEXT_RED_YELLOW:
            begin
                red = one_byte;  green = t_byte;    blue = zero_byte;
            end
            SEXT_YELLOW_GREEN:
            begin
                red = q_byte;    green = one_byte;  blue = zero_byte;
            end
            SEXT_GREEN_CYAN:
            begin
                red = zero_byte; green = one_byte;  blue = t_byte;
            end
            SEXT_CYAN_BLUE:
            begin
                red = zero_byte; green = q_byte;    blue = one_byte;
            end
            SEXT_BLUE_MAGENTA:
            begin
                red = t_byte;    green = zero_byte; blue = one_byte;
            end
            default:
            begin
                red = one_byte;  green = zero_byte; blue = q_byte;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        restart_next   = restart_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        hue_next       = hue_reg;
        v_next         = v_reg;
        rem_next       = rem_reg;
        dsr_next       = dsr_reg;
        dvd_next       = dvd_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_wr_en)
        begin
            hue_next = cfg_wr_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_word.func == FUNC_MEASURE)
                    begin
                        max_next = (in_word.sample_value > start_max)
                                 ? in_word.sample_value : start_max;
                        min_next = ((in_word.sample_value != '0)
                                    && (in_word.sample_value < start_min))
                                 ? in_word.sample_value : start_min;
                        restart_next = in_word.pass_end;
                    end
                    else if (flat)
                    begin
                        v_next     = '0;
                        state_next = ST_MULT;
                    end
                    else if (!below)
                    begin
                        v_next     = V_ONE;
                        state_next = ST_MULT;
                    end
                    else
                    begin
                        rem_next   = num;
                        dsr_next   = den;
                        dvd_next   = '0;
                        quo_next   = '0;
                        cnt_next   = CNT_W'(FRACTION_BITS);
                        state_next = ST_DIV_V;
                    end
                end
            end
            ST_DIV_V:
            begin
                rem_next = rem_step;
                dvd_next = {dvd_reg[HQ_W-2:0], 1'b0};
                quo_next = {quo_reg[HQ_W-2:0], q_bit};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    v_next     = {1'b0, quo_reg[FRACTION_BITS-2:0], q_bit};
                    state_next = ST_MULT;
                end
            end
            ST_MULT:
            begin
                rem_next   = '0;
                dsr_next   = DIV_SEXT;
                dvd_next   = hq_wide[HQ_W-1:0];
                cnt_next   = CNT_W'(HQ_W);
                state_next = ST_DIV_H;
            end
            ST_DIV_H:
            begin
                rem_next = rem_step;
                dvd_next = {dvd_reg[HQ_W-2:0], 1'b0};
                quo_next = {quo_reg[HQ_W-2:0], q_bit};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_word_next.red      = red;
                    out_word_next.green    = green;
                    out_word_next.blue     = blue;
                    out_word_next.min_seen = min_reg;
                    out_word_next.max_seen = max_reg;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            restart_reg   <= 1'b0;
            min_reg       <= SAMPLE_HI;
            max_reg       <= SAMPLE_LO;
            hue_reg       <= HUE_SPAN_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            restart_reg   <= restart_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            hue_reg       <= hue_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        v_reg        <= v_next;
        rem_reg      <= rem_next;
        dsr_reg      <= dsr_next;
        dvd_reg      <= dvd_next;
        quo_reg      <= quo_next;
        out_word_reg <= out_word_next;
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the min/max normalize hue colormap
// ----------------------------------------------------------------------------
// A directed table runs first: sentinel, flat and zero-only ranges, clamping
// below and above, pass_end on a colorize word, and the hue_span extremes.
// A random part of measure passes, each followed by colorize words, then runs
// under several hue_span values and idling patterns. A bit-accurate predictor
// computes every expected pixel word that the directed table does not give,
// and the monitor compares each one field by field.
// ----------------------------------------------------------------------------
module tb_top;

    import mmnhc_pkg::*;

    localparam int FRAC         = FRACTION_BITS_DEF;
    localparam longint unsigned ONE_Q = longint'(1) << FRAC;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;      // long receiver hold-off
    localparam int PHASE_WORDS   = 128;
    localparam int PHASE_COUNT   = 8;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef enum logic [1:0] { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_t;
    typedef enum logic { ROW_WORD, ROW_SPAN } row_kind_t;

    typedef struct {
        row_kind_t           kind;
        sample_word_t        word;
        logic [HUE_BITS-1:0] span;
        bit                  typed;      // expected pixel given in the row
        pixel_word_t         px;
    } stim_row_t;

    // ------------------------------------------------------------------
    // clock, reset and block inputs
    // ------------------------------------------------------------------
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [HUE_BITS-1:0] cfg_wr_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    sample_word_t        in_word = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    pixel_word_t         out_word;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    minmax_normalize_hue_colormap uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word)
    );

    // ------------------------------------------------------------------
    // predictor state: mirrors the extremes tracker and hue_span
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] cur_min = SAMPLE_HI;
    logic signed [SAMPLE_BITS-1:0] cur_max = SAMPLE_LO;
    bit                            restart_due = 1'b0;
    logic [HUE_BITS-1:0]           cur_span = HUE_SPAN_RESET;

    pixel_word_t pending_pixels[$];     // expected pixel words, oldest first
    stim_row_t   directed[$];
    idle_mode_t  idle_mode = IDLE_NONE;
    int          hold_requests = 0;
    int          err_count = 0;
    int unsigned cycle_count = 0;

    // component byte from a Q1.16 intensity, truncated
    function automatic logic [7:0] comp_byte(input longint unsigned c);
        return 8'((c * 255) >> FRAC);
    endfunction

    // normalize against the tracked extremes, then hsv sextant rule, S = V = 1
    function automatic pixel_word_t color_of(input logic signed [SAMPLE_BITS-1:0] x);
        longint unsigned num, den, v, hq, sext, rem, f;
        logic [SEXT_BITS-1:0] sx;
        logic [7:0] full, t, q;
        pixel_word_t p;
        // flat or empty range and samples at or below min give v = 0
        if (cur_max <= cur_min || x <= cur_min)
            v = 0;
        else
        begin
            num = longint'(x) - longint'(cur_min);
            den = longint'(cur_max) - longint'(cur_min);
            v = (num >= den) ? ONE_Q : (num << FRAC) / den;
        end
        hq   = (ONE_Q - v) * cur_span;
        sext = hq / (longint'(SEXTANT_DEG) << FRAC);
        rem  = hq - sext * (longint'(SEXTANT_DEG) << FRAC);
        f    = rem / SEXTANT_DEG;
        // hue past 360 degrees wraps around the circle
        sx   = SEXT_BITS'(sext % SEXTANT_COUNT);
        full = comp_byte(ONE_Q);
        t    = comp_byte(f);
        q    = comp_byte(ONE_Q - f);
        case (sx)
            SEXT_RED_YELLOW:
            begin
                p.red = full; p.green = t;    p.blue = 8'd0;
            end
            SEXT_YELLOW_GREEN:
            begin
                p.red = q;    p.green = full; p.blue = 8'd0;
            end
            SEXT_GREEN_CYAN:
            begin
                p.red = 8'd0; p.green = full; p.blue = t;
            end
            SEXT_CYAN_BLUE:
            begin
                p.red = 8'd0; p.green = q;    p.blue = full;
            end
            SEXT_BLUE_MAGENTA:
            begin
                p.red = t;    p.green = 8'd0; p.blue = full;
            end
            default:
            begin
                p.red = full; p.green = 8'd0; p.blue = q;
            end
        endcase
        p.min_seen = cur_min;
        p.max_seen = cur_max;
        return p;
    endfunction

    // measure word: extremes update, zero counts toward the maximum only
    function automatic void track_extremes(input sample_word_t w);
        if (restart_due)
        begin
            cur_min = SAMPLE_HI;
            cur_max = SAMPLE_LO;
            restart_due = 1'b0;
        end
        if (w.sample_value > cur_max)
            cur_max = w.sample_value;
        if (w.sample_value != 0 && w.sample_value < cur_min)
            cur_min = w.sample_value;
        if (w.pass_end)
            restart_due = 1'b1;
    endfunction

    function automatic sample_word_t mk_word(input logic fn,
                                             input logic signed [SAMPLE_BITS-1:0] val,
                                             input logic pe);
        sample_word_t w;
        w.func = fn;
        w.sample_value = val;
        w.pass_end = pe;
        return w;
    endfunction

    function automatic pixel_word_t px(input int r, input int g, input int b,
                                       input int mn, input int mx);
        pixel_word_t p;
        p.red = r[7:0];
        p.green = g[7:0];
        p.blue = b[7:0];
        p.min_seen = mn[SAMPLE_BITS-1:0];
        p.max_seen = mx[SAMPLE_BITS-1:0];
        return p;
    endfunction

    function automatic bit sender_rests();
        int pct;
        pct = (idle_mode == IDLE_SENDER) ? 56 : (idle_mode == IDLE_BOTH) ? 11 : 0;
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic bit receiver_rests();
        int pct;
        pct = (idle_mode == IDLE_RECEIVER) ? 56 : (idle_mode == IDLE_BOTH) ? 11 : 0;
        return $urandom_range(0, 99) < pct;
    endfunction

    // mixed magnitudes: zero, the range extremes, tiny values, random spreads
    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        logic signed [SAMPLE_BITS-1:0] s;
        case ($urandom_range(0, 9))
            0: s = '0;
            1: s = SAMPLE_HI;
            2: s = SAMPLE_LO;
            3: s = SAMPLE_BITS'(int'($urandom_range(0, 16)) - 8);
            default:
            begin
                s = SAMPLE_BITS'($urandom);
                s = s >>> $urandom_range(0, 22);
            end
        endcase
        return s;
    endfunction

    // ------------------------------------------------------------------
    // sender: entered at a rising edge, leaves at the edge that took the word
    // ------------------------------------------------------------------
    task automatic send_word(input sample_word_t w, input bit typed, input pixel_word_t typed_px);
        while (sender_rests())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        // sample the handshake mid-cycle, away from the edge
        do
            @(negedge clk);
        while (in_stall);
        if (w.func == FUNC_COLORIZE)
            pending_pixels.push_back(typed ? typed_px : color_of(w.sample_value));
        else
            track_extremes(w);
        @(posedge clk);
    endtask

    // hue_span write once the block has gone quiet
    task automatic write_span(input logic [HUE_BITS-1:0] value);
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        // a measure word gives no pixel, so give any work in flight time to end
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_span = value;
    endtask

    // well-formed passes with random content, plus some noise
    task automatic random_phase(input int quota);
        int sent, n, k;
        longint width;
        logic signed [SAMPLE_BITS-1:0] x;
        sent = 0;
        while (sent < quota)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: any func, any pass_end
                n = $urandom_range(1, 4);
                repeat (n)
                    send_word(mk_word(1'($urandom_range(0, 1)), rand_sample(),
                                      1'($urandom_range(0, 1))), 1'b0, '0);
                sent += n;
            end
            else
            begin
                // measure pass, now and then left open without pass_end
                n = $urandom_range(1, 8);
                for (k = 0; k < n; k++)
                    send_word(mk_word(FUNC_MEASURE, rand_sample(),
                                      (k == n - 1) && ($urandom_range(0, 7) != 0)), 1'b0, '0);
                sent += n;
                // colorize words, mostly inside the measured range
                n = $urandom_range(1, 10);
                for (k = 0; k < n; k++)
                begin
                    if (cur_max > cur_min && $urandom_range(0, 3) != 0)
                    begin
                        width = longint'(cur_max) - longint'(cur_min);
                        x = SAMPLE_BITS'(longint'(cur_min) + (longint'($urandom) % (width + 1)));
                    end
                    else
                        x = rand_sample();
                    send_word(mk_word(FUNC_COLORIZE, x, $urandom_range(0, 7) == 0), 1'b0, '0);
                end
                sent += n;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------
    function automatic void add_row(input row_kind_t kind, input logic fn,
                                    input logic signed [SAMPLE_BITS-1:0] val, input logic pe,
                                    input int span, input bit typed, input pixel_word_t p);
        stim_row_t r;
        r.kind  = kind;
        r.word  = mk_word(fn, val, pe);
        r.span  = HUE_BITS'(span);
        r.typed = typed;
        r.px    = p;
        directed.push_back(r);
    endfunction

    function automatic void build_directed();
        int hi, lo;
        hi = int'(SAMPLE_HI);
        lo = -8388608;
        // right after reset the extremes are the sentinels: flat range, blue end
        add_row(ROW_WORD, FUNC_COLORIZE, 0,         1'b0, 0, 1'b1, px(42, 0, 255, hi, lo));
        add_row(ROW_WORD, FUNC_COLORIZE, SAMPLE_HI, 1'b0, 0, 1'b1, px(42, 0, 255, hi, lo));
        // a zero sample moves only the maximum
        add_row(ROW_WORD, FUNC_MEASURE,  0,         1'b0, 0, 1'b0, '0);
        add_row(ROW_WORD, FUNC_COLORIZE, 5,         1'b0, 0, 1'b1, px(42, 0, 255, hi, 0));
        // full range extremes
        add_row(ROW_WORD, FUNC_MEASURE,  SAMPLE_LO, 1'b0, 0, 1'b0, '0);
        add_row(ROW_WORD, FUNC_MEASURE,  SAMPLE_HI, 1'b0, 0, 1'b0, '0);
        add_row(ROW_WORD, FUNC_MEASURE,  100,       1'b1, 0, 1'b0, '0);
        add_row(ROW_WORD, FUNC_COLORIZE, SAMPLE_LO, 1'b0, 0, 1'b1, px(42, 0, 255, lo, hi));
        add_row(ROW_WORD, FUNC_COLORIZE, SAMPLE_HI, 1'b0, 0, 1'b1, px(255, 0, 0, lo, hi));
        add_row(ROW_WORD, FUNC_COLORIZE, 0,         1'b0, 0, 1'b0, '0);
        // pass_end on a colorize word does nothing
        add_row(ROW_WORD, FUNC_COLORIZE, -1,        1'b1, 0, 1'b0, '0);
        // restart from the sentinels, then clamp below and above
        add_row(ROW_WORD, FUNC_MEASURE,  10,        1'b0, 0, 1'b0, '0);
        add_row(ROW_WORD, FUNC_MEASURE,  20,        1'b1, 0, 1'b0, '0);
        add_row(ROW_WORD, FUNC_COLORIZE, 15,        1'b0, 0, 1'b0, '0);
        add_row(ROW_WORD, FUNC_COLORIZE, 5,         1'b0, 0, 1'b1, px(42, 0, 255, 10, 20));
        add_row(ROW_WORD, FUNC_COLORIZE, 30,        1'b0, 0, 1'b1, px(255, 0, 0, 10, 20));
        // a pass of zeros only
        add_row(ROW_WORD, FUNC_MEASURE,  0,         1'b1, 0, 1'b0, '0);
        add_row(ROW_WORD, FUNC_COLORIZE, 0,         1'b0, 0, 1'b1, px(42, 0, 255, hi, 0));
        add_row(ROW_WORD, FUNC_MEASURE,  -50,       1'b0, 0, 1'b0, '0);
        add_row(ROW_WORD, FUNC_MEASURE,  50,        1'b0, 0, 1'b0, '0);
        // zero span paints everything red
        add_row(ROW_SPAN, FUNC_MEASURE,  0,         1'b0, 0, 1'b0, '0);
        add_row(ROW_WORD, FUNC_COLORIZE, 7,         1'b0, 0, 1'b1, px(255, 0, 0, -50, 50));
        // widest span wraps past a full turn
        add_row(ROW_SPAN, FUNC_MEASURE,  0,         1'b0, 511, 1'b0, '0);
        add_row(ROW_WORD, FUNC_COLORIZE, -50,       1'b0, 0, 1'b0, '0);
        add_row(ROW_WORD, FUNC_COLORIZE, 10,        1'b0, 0, 1'b0, '0);
        add_row(ROW_SPAN, FUNC_MEASURE,  0,         1'b0, 1, 1'b0, '0);
        add_row(ROW_WORD, FUNC_COLORIZE, 0,         1'b0, 0, 1'b0, '0);
        add_row(ROW_SPAN, FUNC_MEASURE,  0,         1'b0, 359, 1'b0, '0);
        add_row(ROW_WORD, FUNC_COLORIZE, -20,       1'b0, 0, 1'b0, '0);
    endfunction

    // ------------------------------------------------------------------
    // receiver: random stall, plus a long hold-off on request
    // ------------------------------------------------------------------
    int hold_left = 0;
    int holds_served = 0;

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served = holds_served + 1;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= receiver_rests();
    end

    // ------------------------------------------------------------------
    // monitor: outputs change at the rising edge, so look mid-cycle
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [SAMPLE_BITS-1:0] want,
                               input logic [SAMPLE_BITS-1:0] got);
        if (want !== got)
        begin
            err_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(negedge clk)
    begin : monitor
        pixel_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected pixel word, expected none, actual %h",
                         $time, out_word);
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("red",      SAMPLE_BITS'(want.red),
                            SAMPLE_BITS'(out_word.red));
                check_field("green",    SAMPLE_BITS'(want.green),
                            SAMPLE_BITS'(out_word.green));
                check_field("blue",     SAMPLE_BITS'(want.blue),
                            SAMPLE_BITS'(out_word.blue));
                check_field("min_seen", want.min_seen, out_word.min_seen);
                check_field("max_seen", want.max_seen, out_word.max_seen);
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : main
        int i, ph;
        build_directed();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, no idling
        for (i = 0; i < directed.size(); i++)
        begin
            if (directed[i].kind == ROW_SPAN)
                write_span(directed[i].span);
            else
                send_word(directed[i].word, directed[i].typed, directed[i].px);
        end

        // random phases: each with its own hue_span and idling pattern
        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0: write_span(HUE_BITS'(359));
                1: write_span(HUE_BITS'(0));
                2: write_span(HUE_BITS'(1));
                3: write_span(HUE_BITS'(511));
                4: write_span(HUE_SPAN_RESET);
                default: write_span(HUE_BITS'($urandom_range(0, 511)));
            endcase
            case (ph % 4)
                0: idle_mode = IDLE_NONE;
                1: idle_mode = IDLE_SENDER;
                2: idle_mode = IDLE_RECEIVER;
                default: idle_mode = IDLE_BOTH;
            endcase
            // first phase: receiver holds off while words keep coming
            if (ph == 0)
                hold_requests++;
            random_phase(PHASE_WORDS);
        end

        // drain, then give any stray word time to show up
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/mmnhc_pkg.sv
hw/rtl/minmax_normalize_hue_colormap.sv
verif/tb_top.sv
